>>> sv/vlpe_pkg.sv
package vlpe_pkg;

    localparam int unsigned NumW     = 64;
    localparam int unsigned LenW     = 4;
    localparam int unsigned MaxLen   = 10;
    localparam int unsigned BitsPerL = 7;
    localparam int unsigned CodeW    = 8 * MaxLen;
    localparam int unsigned FifoDepth = 2;

    typedef struct packed {
        logic [NumW-1:0] number;
        logic [LenW-1:0] len;
    } vlpe_item_t;

    // smallest n in 1..9 with v < 2^(7n)-1, else 10
    function automatic logic [LenW-1:0] vlpe_length(input logic [NumW-1:0] v);
        logic [LenW-1:0] n;
        logic [NumW-1:0] lim;
        n = LenW'(MaxLen);
        for (int i = MaxLen - 1; i >= 1; i--) begin
            lim = (NumW'(1) << (BitsPerL * i)) - NumW'(1);
            if (v < lim) begin
                n = LenW'(i);
            end
        end
        return n;
    endfunction

endpackage

>>> sv/vlpe_front.sv
module vlpe_front (
    input  logic                      s_valid,
    output logic                      s_ready,
    input  logic [63:0]               s_number_in,
    input  logic                      q_full,
    output logic                      q_push,
    output vlpe_pkg::vlpe_item_t      q_item
);
    import vlpe_pkg::*;

    // classify: pick the encoded length, queue value and length
    assign s_ready       = !q_full;
    assign q_push        = s_valid && !q_full;
    assign q_item.number = s_number_in;
    assign q_item.len    = vlpe_length(s_number_in);

endmodule

>>> sv/vlpe_fifo.sv
module vlpe_fifo (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 push,
    input  vlpe_pkg::vlpe_item_t push_item,
    output logic                 full,
    input  logic                 pop,
    output logic                 not_empty,
    output vlpe_pkg::vlpe_item_t head_item
);
    import vlpe_pkg::*;

    localparam int unsigned PtrW = $clog2(FifoDepth);
    localparam int unsigned CntW = $clog2(FifoDepth + 1);

    vlpe_item_t          slot_reg [FifoDepth];
    logic [PtrW-1:0]     wr_ptr_reg, wr_ptr_next;
    logic [PtrW-1:0]     rd_ptr_reg, rd_ptr_next;
    logic [CntW-1:0]     count_reg, count_next;

    assign full      = (count_reg == CntW'(FifoDepth));
    assign not_empty = (count_reg != '0);
    assign head_item = slot_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == PtrW'(FifoDepth - 1)) ? '0 : wr_ptr_reg + PtrW'(1);
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == PtrW'(FifoDepth - 1)) ? '0 : rd_ptr_reg + PtrW'(1);
        end
        if (push && !pop) begin
            count_next = count_reg + CntW'(1);
        end else if (pop && !push) begin
            count_next = count_reg - CntW'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            slot_reg[wr_ptr_reg] <= push_item;
        end
    end

endmodule

>>> sv/vlpe_back.sv
module vlpe_back (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 q_not_empty,
    input  vlpe_pkg::vlpe_item_t q_item,
    output logic                 q_pop,
    output logic                 m_valid,
    input  logic                 m_ready,
    output logic [7:0]           m_code_byte,
    output logic                 m_last_byte
);
    import vlpe_pkg::*;

    localparam int unsigned PosW = $clog2(CodeW);

    logic                 active_reg, active_next;
    logic [NumW-1:0]      number_reg;
    logic [LenW-1:0]      idx_reg, idx_next;
    logic [LenW-1:0]      mark_byte_reg;
    logic [2:0]           mark_bit_reg;
    logic                 out_valid_reg, out_valid_next;
    logic [7:0]           out_byte_reg;
    logic                 out_last_reg;

    logic                 out_free;
    logic                 emit;
    logic                 load;
    logic [CodeW-1:0]     data_ext;
    logic [7:0]           cur_byte;
    logic [PosW-1:0]      mark_pos;

    assign out_free = !out_valid_reg || m_ready;
    assign emit     = active_reg && out_free;
    assign load     = q_not_empty && (!active_reg || (emit && idx_reg == '0));
    assign q_pop    = load;

    // marker sits at bit 7n of the code word
    assign mark_pos = {q_item.len, 3'b000} - PosW'(q_item.len);

    assign data_ext = {{(CodeW - NumW){1'b0}}, number_reg};
    always_comb begin
        cur_byte = data_ext[{idx_reg, 3'b000} +: 8];
        if (idx_reg == mark_byte_reg) begin
            cur_byte = cur_byte | (8'd1 << mark_bit_reg);
        end
    end

    always_comb begin
        active_next    = active_reg;
        idx_next       = idx_reg;
        out_valid_next = out_valid_reg && !m_ready;
        if (emit) begin
            out_valid_next = 1'b1;
            idx_next       = idx_reg - LenW'(1);
            if (idx_reg == '0) begin
                active_next = 1'b0;
            end
        end
        if (load) begin
            active_next = 1'b1;
            idx_next    = q_item.len - LenW'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            active_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            active_reg    <= active_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        idx_reg <= idx_next;
        if (load) begin
            number_reg    <= q_item.number;
            mark_byte_reg <= mark_pos[PosW-1:3];
            mark_bit_reg  <= mark_pos[2:0];
        end
        if (emit) begin
            out_byte_reg <= cur_byte;
            out_last_reg <= (idx_reg == '0);
        end
    end

    assign m_valid     = out_valid_reg;
    assign m_code_byte = out_byte_reg;
    assign m_last_byte = out_last_reg;

endmodule

>>> sv/vint_length_prefixed_encoder_core.sv
// Length-prefixed variable-length integer encoder.
// Input channel (s_valid/s_ready/s_number_in): one 64-bit unsigned value per
// request. Output channel (m_valid/m_ready/m_code_byte/m_last_byte): the
// encoding, one byte per request, most significant byte first; m_last_byte
// flags the final byte of each value. A value takes n = 1..10 bytes.
// Path: length classify -> 2-entry queue -> byte emitter -> output register.
// Throughput: one output byte per cycle while m_ready is high; the byte
// emitter is the bottleneck, the front takes new values as long as the
// queue has room, so input is taken while the emitter is still busy on
// earlier values.
// Receiver stall: the output register holds its byte, the emitter stops,
// the queue fills and s_ready drops once it holds two values.
// Reset (aresetn, synchronous, active low) empties the queue, drops the
// emitter and the output valid; no values are in flight afterwards.
module vint_length_prefixed_encoder_core (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [63:0] s_number_in,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [7:0]  m_code_byte,
    output logic        m_last_byte
);
    import vlpe_pkg::*;

    vlpe_item_t push_item;
    vlpe_item_t head_item;
    logic       q_full;
    logic       q_push;
    logic       q_pop;
    logic       q_not_empty;

    // front: take value, compute length
    vlpe_front u_front (
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_number_in (s_number_in),
        .q_full      (q_full),
        .q_push      (q_push),
        .q_item      (push_item)
    );

    // decoupling queue between classify and emit
    vlpe_fifo u_fifo (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (q_push),
        .push_item (push_item),
        .full      (q_full),
        .pop       (q_pop),
        .not_empty (q_not_empty),
        .head_item (head_item)
    );

    // back: byte-serial emitter with output register
    vlpe_back u_back (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .q_not_empty (q_not_empty),
        .q_item      (head_item),
        .q_pop       (q_pop),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_code_byte (m_code_byte),
        .m_last_byte (m_last_byte)
    );

endmodule

>>> sim/tb_top.sv
module tb_top;
    import vlpe_pkg::*;

    // One expected output byte of an encoding.
    typedef struct packed {
        logic [7:0] code;
        logic       last;
    } code_byte_t;

    logic        aclk        = 1'b0;
    logic        aresetn     = 1'b0;
    logic        s_valid     = 1'b0;
    logic        s_ready;
    logic [63:0] s_number_in = '0;
    logic        m_valid;
    logic        m_ready     = 1'b0;
    logic [7:0]  m_code_byte;
    logic        m_last_byte;

    // Values waiting to be sent, and bytes the encoder still owes us.
    logic [NumW-1:0] pending_values[$];
    code_byte_t      expected_bytes[$];

    int unsigned mismatch_count = 0;
    int unsigned idle_pct       = 0;    // sender: chance of an idle cycle
    int unsigned stall_pct      = 0;    // receiver: chance of a stall cycle

    vint_length_prefixed_encoder_core u_top (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_number_in (s_number_in),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_code_byte (m_code_byte),
        .m_last_byte (m_last_byte)
    );

    always #5 aclk = ~aclk;

    // Number of encoded bytes: smallest n in 1..9 with v below 2^(7n)-1,
    // otherwise 10. The all-ones data pattern of each length is skipped.
    // Compare in 65 bits so that 2^63-1 is formed without wrapping.
    function automatic int unsigned encoded_length(input logic [NumW-1:0] v);
        logic [NumW:0] lim;
        for (int unsigned n = 1; n < MaxLen; n++) begin
            lim = ((NumW+1)'(1) << (BitsPerL * n)) - (NumW+1)'(1);
            if ({1'b0, v} < lim) begin
                return n;
            end
        end
        return MaxLen;
    endfunction

    // Build the 8n-bit frame: the value zero-extended, marker one bit at
    // position 7n, leading zeros above it. Bytes go out MSB first.
    task automatic predict_encoding(input logic [NumW-1:0] v);
        int unsigned  n;
        logic [79:0]  frame;
        code_byte_t   b;
        n     = encoded_length(v);
        frame = {16'b0, v} | (80'd1 << (BitsPerL * n));
        for (int unsigned k = 0; k < n; k++) begin
            b.code = frame[8 * (n - 1 - k) +: 8];
            b.last = (k + 1 == n);
            expected_bytes.push_back(b);
        end
    endtask

    // Random value, biased toward the length boundaries and toward short
    // bit widths so every length from 1 to 10 gets plenty of traffic.
    function automatic logic [NumW-1:0] random_value();
        logic [NumW-1:0] v;
        int unsigned     pick;
        int unsigned     w;
        int unsigned     n;
        v    = {$urandom, $urandom};
        pick = $urandom_range(99);
        if (pick < 20) begin
            // 2^(7n) down to 2^(7n)-3: straddles the reserved pattern
            n = $urandom_range(1, 9);
            v = (64'd1 << (BitsPerL * n)) - 64'($urandom_range(3));
        end else if (pick < 75) begin
            w = $urandom_range(1, 64);
            if (w < 64) begin
                v &= (64'd1 << w) - 64'd1;
            end
        end
        return v;
    endfunction

    // Driver: a request stays up, payload unchanged, until accepted; a new
    // one is picked only once the current one is gone.
    always @(posedge aclk) begin
        logic send;
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else if (!s_valid || s_ready) begin
            send = (pending_values.size() != 0) && ($urandom_range(99) >= idle_pct);
            if (send) begin
                s_number_in <= pending_values.pop_front();
            end
            s_valid <= send;
        end
    end

    // Receiver back-pressure.
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            m_ready <= ($urandom_range(99) >= stall_pct);
        end
    end

    // Monitor: owns the expected-byte queue. Accepted inputs are turned
    // into expected bytes before the output side is checked; an input passes
    // the queue, the emitter and the output register before any of its bytes
    // is shown, so no byte can belong to an input taken on the same edge.
    always @(posedge aclk) begin
        code_byte_t want;
        if (aresetn) begin
            if (s_valid && s_ready) begin
                predict_encoding(s_number_in);
            end
            if (m_valid && m_ready) begin
                if (expected_bytes.size() == 0) begin
                    mismatch_count++;
                    if (mismatch_count <= 10) begin
                        $display("unexpected byte: code=%02h last=%0b",
                                 m_code_byte, m_last_byte);
                    end
                end else begin
                    want = expected_bytes.pop_front();
                    if (m_code_byte !== want.code || m_last_byte !== want.last) begin
                        mismatch_count++;
                        if (mismatch_count <= 10) begin
                            $display({"byte mismatch: expected code=%02h last=%0b,",
                                      " got code=%02h last=%0b"},
                                     want.code, want.last, m_code_byte, m_last_byte);
                        end
                    end
                end
            end
        end
    end

    // Stimulus, in four flow-control phases. Each phase drains fully
    // before the next starts, so the sender sits idle while the encoder
    // finishes everything it owes.
    initial begin
        int unsigned phase_idle[4];
        int unsigned phase_stall[4];
        phase_idle  = '{0, 69, 0, 13};
        phase_stall = '{0, 0, 69, 13};

        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;

        for (int ph = 0; ph < 4; ph++) begin
            idle_pct  = phase_idle[ph];
            stall_pct = phase_stall[ph];
            if (ph == 0) begin
                // Extremes and checkerboards.
                pending_values.push_back(64'd0);
                pending_values.push_back(64'd1);
                pending_values.push_back(64'h8000_0000_0000_0000);
                pending_values.push_back(64'hffff_ffff_ffff_ffff);
                pending_values.push_back(64'h5555_5555_5555_5555);
                pending_values.push_back(64'haaaa_aaaa_aaaa_aaaa);
                // Just below each reserved all-ones pattern and the pattern
                // itself, which must move up one length. The last pair is
                // 2^63-2 (nine bytes) and 2^63-1 (ten bytes).
                for (int unsigned n = 1; n < MaxLen; n++) begin
                    pending_values.push_back((64'd1 << (BitsPerL * n)) - 64'd2);
                    pending_values.push_back((64'd1 << (BitsPerL * n)) - 64'd1);
                end
            end
            repeat (75) pending_values.push_back(random_value());
            while (pending_values.size() != 0 || s_valid || expected_bytes.size() != 0) begin
                @(posedge aclk);
            end
        end

        // Let any stray output show up before closing.
        repeat (20) @(posedge aclk);
        if (expected_bytes.size() != 0) begin
            mismatch_count += expected_bytes.size();
        end
        if (mismatch_count == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

    // Watchdog: far beyond the slowest legal run.
    initial begin
        #5000000;
        $display("end of test: mismatches");
        $finish;
    end

endmodule
